@@ rtl/sqd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqd_pkg: shared types for the shortest-queue dispatcher
// Scan token passed along the row of line cells.
// ----------------------------------------------------------------------------
package sqd_pkg;

   localparam int TIME_W = 16;
   localparam int SVC_W  = 10;

   // configuration register indexes
   localparam logic [1:0] REG_SERVERS  = 2'd0;
   localparam logic [1:0] REG_CAPACITY = 2'd1;
   localparam logic [1:0] REG_CLOSE    = 2'd2;

   // token carried cell to cell during a scan
   typedef struct packed {
      logic        found;     // a line with room was found
      logic [6:0]  best_len;  // shortest length seen so far
      logic [4:0]  best_idx;  // index of that line
      logic        any_head;  // some line holds a head
      logic [16:0] earliest;  // earliest head time seen
   } scan_type;

   // command broadcast to all cells
   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_CLEAR = 3'd1,
      CMD_SCAN  = 3'd2,
      CMD_POP   = 3'd3,
      CMD_PUSH  = 3'd4
   } cmd_type;

endpackage

@@ rtl/sqd_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqd_cell: one server line
// Holds the FIFO of finish times, the count and the tail time of one line.
// ----------------------------------------------------------------------------
module sqd_cell #(
   parameter int IDX     = 0,
   parameter int MAX_CAP = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sqd_pkg::cmd_type                 cmd,
   input  logic                             active,   // token reached this cell
   input  logic                             in_use,   // index below server count
   input  logic [6:0]                       cap,
   input  logic [sqd_pkg::TIME_W-1:0]       push_time,
   input  logic                             push_sel,
   input  logic [16:0]                      pop_time,
   input  sqd_pkg::scan_type                tok_i,
   output sqd_pkg::scan_type                tok_o,
   output logic                             popped,
   output logic [sqd_pkg::TIME_W-1:0]       tail
);
   localparam int CW = $clog2(MAX_CAP + 1);
   localparam int AW = (MAX_CAP > 1) ? $clog2(MAX_CAP) : 1;

   logic [sqd_pkg::TIME_W-1:0] fifo_ff [MAX_CAP];
   logic [CW-1:0]              count_ff, count_in;
   logic [sqd_pkg::TIME_W-1:0] tail_ff, tail_in;
   sqd_pkg::scan_type          tok_ff, tok_in;
   logic                       hit;
   logic [6:0]                 cnt7;

   assign cnt7  = 7'(count_ff);
   assign hit   = in_use && (count_ff != '0) && ({1'b0, fifo_ff[0]} == pop_time);
   assign popped = hit;
   assign tail  = tail_ff;
   assign tok_o = tok_ff;

   always_comb begin
      tok_in   = tok_i;
      count_in = count_ff;
      tail_in  = tail_ff;
      unique case (cmd)
         sqd_pkg::CMD_CLEAR: begin
            count_in = '0;
            tail_in  = '0;
         end
         sqd_pkg::CMD_POP: begin
            if (hit) count_in = count_ff - CW'(1);
         end
         sqd_pkg::CMD_PUSH: begin
            if (push_sel) begin
               tail_in = push_time;
               if (count_ff < CW'(MAX_CAP)) count_in = count_ff + CW'(1);
            end
         end
         default: begin
         end
      endcase
      if (active && in_use) begin
         if (!tok_i.found || tok_i.best_len > cnt7) begin
            if (cnt7 < cap && (!tok_i.found || cnt7 < tok_i.best_len)) begin
               tok_in.found    = 1'b1;
               tok_in.best_len = cnt7;
               tok_in.best_idx = 5'(IDX);
            end
         end
         if (count_ff != '0 && {1'b0, fifo_ff[0]} < tok_i.earliest) begin
            tok_in.earliest = {1'b0, fifo_ff[0]};
            tok_in.any_head = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         tail_ff  <= '0;
      end else begin
         count_ff <= count_in;
         tail_ff  <= tail_in;
      end
      if (active) tok_ff <= tok_in;
      if (cmd == sqd_pkg::CMD_POP && hit) begin
         for (int k = 0; k < MAX_CAP - 1; k++) fifo_ff[k] <= fifo_ff[k+1];
      end else if (cmd == sqd_pkg::CMD_PUSH && push_sel && count_ff < CW'(MAX_CAP)) begin
         fifo_ff[AW'(count_ff)] <= push_time;
      end
   end
endmodule

@@ rtl/shortest_queue_dispatch_completion.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_queue_dispatch_completion: join-shortest-queue job dispatcher
// Places each job on one of several bounded server lines.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one job: tuser = first_of_batch, tdata[9:0] = service_time.
//   rsp_ returns one item per job: server_index, finish_time, served and
//   time_saturated packed in tdata.
//   csr_ writes num_servers (0), queue_capacity (1), close_time (2).
// Operation: a scan token walks a row of MAX_SERVERS line cells, one cell
// a cycle, collecting the shortest line with room and the earliest head.
// A pick cycle then reads the token. When every line is full, a pop cycle
// removes all heads equal to the earliest time and the lowest popped line
// is chosen. A push cycle then writes the finish time into the chosen line.
// A first_of_batch job adds a clear cycle that empties all lines first.
// Throughput: one job in flight; the next job is accepted only after the
// push cycle has returned to idle.
// Reset clears all lines and tails and loads 2, 2, 540 into the registers.
// A finished item waits in the output register while rsp_tready is low;
// the next job is taken only after it leaves.
// ----------------------------------------------------------------------------
module shortest_queue_dispatch_completion #(
   parameter int MAX_SERVERS  = 20,
   parameter int MAX_CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [9:0] service_time
   input  logic        req_tuser,    // first_of_batch
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [4:0] server_index, [20:5] finish_time,
                                     // [21] served, [22] time_saturated
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);
   localparam int SW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_CLEAR, S_SCAN, S_PICK, S_POP, S_PUSH
   } state_type;

   state_type         state_ff;
   logic [4:0]        nsrv_ff;
   logic [4:0]        cap_ff;
   logic [9:0]        close_ff;
   logic [9:0]        svc_ff;
   logic [5:0]        step_ff;
   logic [4:0]        best_ff;
   logic [16:0]       pop_ff;
   logic [23:0]       out_ff;
   logic              out_v_ff;
   sqd_pkg::cmd_type  cmd;

   logic [5:0]        n_eff;
   logic [6:0]        c_eff;
   sqd_pkg::scan_type tok [MAX_SERVERS+1];
   logic [MAX_SERVERS-1:0] popped;
   logic [sqd_pkg::TIME_W-1:0] tails [MAX_SERVERS];
   logic [4:0]        pop_idx;
   logic              pop_any;
   logic [16:0]       fin;
   logic [15:0]       start;

   // clamp configuration to legal range
   always_comb begin
      n_eff = (nsrv_ff == 5'd0) ? 6'd1 : 6'(nsrv_ff);
      if (n_eff > 6'(MAX_SERVERS)) n_eff = 6'(MAX_SERVERS);
      c_eff = (cap_ff == 5'd0) ? 7'd1 : 7'(cap_ff);
      if (c_eff > 7'(MAX_CAPACITY)) c_eff = 7'(MAX_CAPACITY);
   end

   assign tok[0] = '{found: 1'b0, best_len: 7'd0, best_idx: 5'd0,
                     any_head: 1'b0, earliest: 17'h10000};

   always_comb begin
      unique case (state_ff)
         S_CLEAR: cmd = sqd_pkg::CMD_CLEAR;
         S_POP:   cmd = sqd_pkg::CMD_POP;
         S_PUSH:  cmd = sqd_pkg::CMD_PUSH;
         default: cmd = sqd_pkg::CMD_NONE;
      endcase
   end

   genvar g;
   generate
      for (g = 0; g < MAX_SERVERS; g++) begin : g_cell
         sqd_cell #(.IDX(g), .MAX_CAP(MAX_CAPACITY)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd),
            .active    (state_ff == S_SCAN && step_ff == 6'(g)),
            .in_use    (6'(g) < n_eff),
            .cap       (c_eff),
            .push_time (fin[16] ? 16'hFFFF : fin[15:0]),
            .push_sel  (best_ff == 5'(g)),
            .pop_time  (pop_ff),
            .tok_i     (tok[g]),
            .tok_o     (tok[g+1]),
            .popped    (popped[g]),
            .tail      (tails[g])
         );
      end
   endgenerate

   // lowest popped line
   always_comb begin
      pop_idx = 5'd0;
      pop_any = 1'b0;
      for (int k = MAX_SERVERS - 1; k >= 0; k--) begin
         if (popped[k]) begin
            pop_idx = 5'(k);
            pop_any = 1'b1;
         end
      end
   end

   assign start = tails[SW'(best_ff)];
   assign fin   = 17'(start) + 17'(svc_ff);

   assign req_tready = (state_ff == S_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         nsrv_ff  <= 5'd2;
         cap_ff   <= 5'd2;
         close_ff <= 10'd540;
         out_v_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               sqd_pkg::REG_SERVERS:  nsrv_ff  <= csr_wdata[4:0];
               sqd_pkg::REG_CAPACITY: cap_ff   <= csr_wdata[4:0];
               sqd_pkg::REG_CLOSE:    close_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (out_v_ff && rsp_tready) out_v_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  svc_ff   <= req_tdata[9:0];
                  step_ff  <= '0;
                  state_ff <= req_tuser ? S_CLEAR : S_SCAN;
               end
            end
            S_CLEAR: state_ff <= S_SCAN;
            S_SCAN: begin
               // advance token one cell a cycle
               if (step_ff == 6'(MAX_SERVERS - 1)) state_ff <= S_PICK;
               step_ff <= step_ff + 6'd1;
            end
            S_PICK: begin
               // token settled at the end of the row
               if (tok[MAX_SERVERS].found) begin
                  best_ff  <= tok[MAX_SERVERS].best_idx;
                  state_ff <= S_PUSH;
               end else begin
                  pop_ff   <= tok[MAX_SERVERS].earliest;
                  state_ff <= S_POP;
               end
            end
            S_POP: begin
               // cells drop their matching heads this cycle
               best_ff  <= pop_any ? pop_idx : 5'd0;
               state_ff <= S_PUSH;
            end
            S_PUSH: begin
               out_ff   <= {1'b0, fin[16], start < 16'(close_ff),
                            fin[16] ? 16'hFFFF : fin[15:0], best_ff};
               out_v_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ rtl/sqd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqd_checker: port-level checks for the dispatcher
// Watches handshakes and result fields on the top level.
// ----------------------------------------------------------------------------
module sqd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   // hold result until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under stall");

   // one job at a time: no accept while a result waits
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("accept while result pending");

   // a result never appears the cycle after accept
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid)
      else $error("result too early");

   // saturated finish time is clamped
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[22] |-> rsp_tdata[20:5] == 16'hFFFF)
      else $error("saturation flag without clamp");
endmodule

bind shortest_queue_dispatch_completion sqd_checker u_sqd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
